[rtl/core/dtcc_pkg.sv]
// Shared types and constants of the delay-target window controller.
package dtcc_pkg;

    localparam int RTT_W   = 24;
    localparam int SEQ_W   = 32;
    localparam int SEG_W   = 16;
    localparam int ALPHA_W = 12;
    localparam int TGT_W   = 36;
    localparam int CNT_W   = 8;
    localparam int DIV_W   = 64;
    localparam int DEN_W   = 36;
    localparam int STEP_W  = 7;

    // Item kinds decided at the front.
    localparam logic [1:0] KIND_SKIP   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;

    // Result action codes.
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SLOW   = 2'd1;
    localparam logic [1:0] ACT_RECOMP = 2'd2;
    localparam logic [1:0] ACT_FEW    = 2'd3;

    // Configuration register indexes.
    localparam logic [7:0] CFG_ALPHA = 8'd0;
    localparam logic [7:0] CFG_SEG   = 8'd1;

    // Divider step counts for each kind of division.
    localparam logic [STEP_W-1:0] STEPS_32 = 7'd32;
    localparam logic [STEP_W-1:0] STEPS_64 = 7'd64;

    typedef struct packed {
        logic [1:0]       kind;
        logic [RTT_W-1:0] rtt_sample_us;
        logic [15:0]      acked_segments;
        logic [SEQ_W-1:0] acked_seq;
        logic [SEQ_W-1:0] next_send_seq;
        logic [RTT_W-1:0] latest_rtt_us;
        logic [SEQ_W-1:0] inflight_bytes;
        logic [SEQ_W-1:0] window_bytes;
        logic [SEQ_W-1:0] threshold_bytes;
    } t_item;

endpackage

[rtl/core/dtcc_div.sv]
// Restoring divider, one quotient bit per cycle.
module dtcc_div
    import dtcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_rem
);

    logic [DIV_W-1:0]  r_acc;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    n_trial;

    assign n_trial = {r_rem, r_acc[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The numerator arrives aligned to the top, so after the steps the
    // quotient sits in the low bits of the accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (n_trial >= {1'b0, r_den}) begin
                r_rem <= DEN_W'(n_trial - {1'b0, r_den});
                r_acc <= {r_acc[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= n_trial[DEN_W-1:0];
                r_acc <= {r_acc[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_acc;
    assign o_rem  = r_rem;

endmodule

[rtl/core/dtcc_front.sv]
// Input side: takes beats, tags their kind and holds them in a short queue.
module dtcc_front
    import dtcc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [223:0]     i_data,
    output logic             o_q_valid,
    input  logic             i_q_pop,
    output t_item            o_q_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_Q-1:0] r_cnt;
    t_item            n_item;
    logic             n_push;
    logic             n_pop;

    always_comb begin
        n_item.rtt_sample_us   = i_data[23:0];
        n_item.acked_segments  = i_data[39:24];
        n_item.acked_seq       = i_data[71:40];
        n_item.next_send_seq   = i_data[103:72];
        n_item.latest_rtt_us   = i_data[127:104];
        n_item.inflight_bytes  = i_data[159:128];
        n_item.window_bytes    = i_data[191:160];
        n_item.threshold_bytes = i_data[223:192];
        if (i_command)
            n_item.kind = KIND_ACK;
        else if (i_data[23:0] != '0)
            n_item.kind = KIND_SAMPLE;
        else
            n_item.kind = KIND_SKIP;
    end

    assign o_ready   = (r_cnt != CNT_Q'(DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign n_push    = i_valid && o_ready;
    assign n_pop     = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_push)
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (n_pop)
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (n_push && !n_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (n_pop && !n_push)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push)
            r_mem[r_wr] <= n_item;
    end

endmodule

[rtl/core/dtcc_back.sv]
// Back end: keeps the RTT state and carries out each queued item.
module dtcc_back
    import dtcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic [SEG_W-1:0]   i_seg,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  t_item              i_q_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SEQ_W-1:0]   o_window,
    output logic [SEQ_W-1:0]   o_threshold,
    output logic [1:0]         o_action
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TGT  = 4'd1;
    localparam logic [3:0] ST_R0   = 4'd2;
    localparam logic [3:0] ST_DW   = 4'd3;
    localparam logic [3:0] ST_DL   = 4'd4;
    localparam logic [3:0] ST_DCUT = 4'd5;
    localparam logic [3:0] ST_PROD = 4'd6;
    localparam logic [3:0] ST_CGO  = 4'd7;
    localparam logic [3:0] ST_DC   = 4'd8;
    localparam logic [3:0] ST_LP   = 4'd9;
    localparam logic [3:0] ST_DIFF = 4'd10;
    localparam logic [3:0] ST_MUL  = 4'd11;
    localparam logic [3:0] ST_QGO  = 4'd12;
    localparam logic [3:0] ST_DQ   = 4'd13;
    localparam logic [3:0] ST_WN   = 4'd14;
    localparam logic [3:0] ST_FIN  = 4'd15;

    logic [3:0]         r_state;
    t_item              r_item;
    logic [RTT_W-1:0]   r_min;
    logic [TGT_W-1:0]   r_target;
    logic [CNT_W-1:0]   r_count;
    logic [SEQ_W-1:0]   r_edge;
    logic [SEQ_W-1:0]   r_w;
    logic [SEQ_W-1:0]   r_l;
    logic [SEQ_W-1:0]   r_thr;
    logic [SEQ_W-1:0]   r_q10;
    logic [DEN_W-1:0]   r_den;
    logic               r_cut_en;
    logic [55:0]        r_prod;
    logic [DIV_W-1:0]   r_c;
    logic [33:0]        r_lp;
    logic               r_neg;
    logic [32:0]        r_diff;
    logic [56:0]        r_mag;
    logic signed [59:0] r_wn;
    logic [57:0]        r_wf;
    logic               r_out_valid;
    logic [SEQ_W-1:0]   r_out_win;
    logic [SEQ_W-1:0]   r_out_thr;
    logic [1:0]         r_out_act;

    logic               r_div_start;
    logic [DIV_W-1:0]   r_div_num;
    logic [DEN_W-1:0]   r_div_den;
    logic [STEP_W-1:0]  r_div_steps;
    logic               n_div_done;
    logic [DIV_W-1:0]   n_quo;
    logic [DEN_W-1:0]   n_rem;

    logic [SEG_W-1:0]   n_seg;
    logic [SEQ_W-1:0]   n_aseq_diff;
    logic [32:0]        n_ss_sum;
    logic [63:0]        n_recip;
    logic [SEQ_W-1:0]   n_rem10;
    logic [SEQ_W-1:0]   n_cut;
    logic [SEQ_W-1:0]   n_nt;
    logic [33:0]        n_sum;
    logic [33:0]        n_lp;
    logic [57:0]        n_qadj;
    logic [57:0]        n_wc;
    logic [47:0]        n_fin;
    logic [RTT_W-1:0]   n_r;
    logic               n_start;

    dtcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .i_steps (r_div_steps),
        .o_done  (n_div_done),
        .o_quo   (n_quo),
        .o_rem   (n_rem)
    );

    assign n_seg       = (i_seg == '0) ? 16'd1 : i_seg;
    assign n_r         = (r_item.latest_rtt_us == '0) ? 24'd1 : r_item.latest_rtt_us;
    assign n_start     = (r_state == ST_IDLE) && i_q_valid && !r_out_valid;
    assign o_q_pop     = n_start;
    assign n_aseq_diff = i_q_item.acked_seq - r_edge;
    assign n_ss_sum    = {1'b0, i_q_item.window_bytes} + {17'd0, n_seg};
    // Nine tenths of the window: with q = w/10 from a reciprocal multiply and
    // r = w - 10q, the floor of 9w/10 is 9q plus r-1 when r is nonzero.
    assign n_recip     = {32'd0, r_item.window_bytes} * {32'd0, 32'hCCCC_CCCD};
    assign n_rem10     = r_item.window_bytes - (r_q10 * 32'd10);
    assign n_cut       = (r_q10 * 32'd9) + ((n_rem10 == '0) ? 32'd0 : n_rem10 - 32'd1);
    assign n_nt        = (r_thr < n_cut) ? r_thr : n_cut;
    assign n_sum       = {2'b0, r_w} + {2'b0, r_l};
    assign n_qadj      = {1'b0, n_quo[56:0]} + {57'd0, (!r_neg && n_rem != '0)};
    assign n_fin       = r_wf[SEQ_W-1:0] * n_seg;

    always_comb begin
        n_lp = (r_c[DIV_W-1:34] == '0 && n_sum > r_c[33:0]) ?
               n_sum - r_c[33:0] : 34'd4;
        if (n_lp < 34'd4)
            n_lp = 34'd4;
        if (n_lp == {2'b0, r_l})
            n_lp = {2'b0, r_l} + 34'd1;
    end

    always_comb begin
        if (r_wn < 60'sd4)
            n_wc = 58'd4;
        else
            n_wc = r_wn[57:0];
        if (n_wc == {26'd0, r_w})
            n_wc = {26'd0, r_w} + 58'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min       <= '1;
            r_target    <= '0;
            r_count     <= '0;
            r_edge      <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (n_start) begin
                        r_item    <= i_q_item;
                        r_out_win <= i_q_item.window_bytes;
                        r_out_thr <= i_q_item.threshold_bytes;
                        r_out_act <= ACT_NONE;
                        unique case (i_q_item.kind)
                            KIND_SAMPLE: begin
                                if (i_q_item.rtt_sample_us < r_min)
                                    r_min <= i_q_item.rtt_sample_us;
                                if (r_count != '1)
                                    r_count <= r_count + 1'b1;
                                r_state <= ST_TGT;
                            end
                            KIND_ACK: begin
                                if (!n_aseq_diff[SEQ_W-1]) begin
                                    if (r_count <= 8'd2) begin
                                        r_out_act   <= ACT_FEW;
                                        r_out_valid <= 1'b1;
                                    end else begin
                                        r_edge  <= i_q_item.next_send_seq;
                                        r_count <= '0;
                                        r_state <= ST_R0;
                                    end
                                end else begin
                                    if (i_q_item.window_bytes < i_q_item.threshold_bytes &&
                                        {4'd0, i_q_item.latest_rtt_us, 8'd0} < r_target) begin
                                        if (i_q_item.acked_segments != '0)
                                            r_out_win <= n_ss_sum[32] ? '1 : n_ss_sum[31:0];
                                        r_edge    <= i_q_item.next_send_seq;
                                        r_out_act <= ACT_SLOW;
                                    end
                                    r_out_valid <= 1'b1;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_TGT: begin
                    r_target    <= i_alpha * r_min;
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                ST_R0: begin
                    r_cut_en    <= ({7'd0, r_item.latest_rtt_us} * 31'd100) >
                                   ({7'd0, r_min} * 31'd101);
                    r_den       <= i_alpha * r_min;
                    r_thr       <= r_item.threshold_bytes;
                    r_q10       <= {3'd0, n_recip[63:35]};
                    r_div_start <= 1'b1;
                    r_div_num   <= {r_item.window_bytes, 32'd0};
                    r_div_den   <= {20'd0, n_seg};
                    r_div_steps <= STEPS_32;
                    r_state     <= ST_DW;
                end
                ST_DW: begin
                    if (n_div_done) begin
                        r_w         <= n_quo[SEQ_W-1:0];
                        r_div_start <= 1'b1;
                        r_div_num   <= {r_item.inflight_bytes, 32'd0};
                        r_div_den   <= {20'd0, n_seg};
                        r_div_steps <= STEPS_32;
                        r_state     <= ST_DL;
                    end
                end
                ST_DL: begin
                    if (n_div_done) begin
                        r_l <= n_quo[SEQ_W-1:0];
                        if (r_cut_en)
                            r_state <= ST_DCUT;
                        else
                            r_state <= ST_PROD;
                    end
                end
                ST_DCUT: begin
                    r_thr   <= (n_nt < {15'd0, n_seg, 1'b0}) ? {15'd0, n_seg, 1'b0} : n_nt;
                    r_state <= ST_PROD;
                end
                ST_PROD: begin
                    r_prod  <= r_w * r_item.latest_rtt_us;
                    r_state <= ST_CGO;
                end
                ST_CGO: begin
                    r_div_start <= 1'b1;
                    r_div_num   <= {r_prod, 8'd0};
                    r_div_den   <= (r_den == '0) ? 36'd1 : r_den;
                    r_div_steps <= STEPS_64;
                    r_state     <= ST_DC;
                end
                ST_DC: begin
                    if (n_div_done) begin
                        r_c     <= n_quo + {63'd0, (n_rem != '0)};
                        r_state <= ST_LP;
                    end
                end
                ST_LP: begin
                    r_lp    <= n_lp;
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_neg   <= r_lp < {2'b0, r_l};
                    r_diff  <= (r_lp < {2'b0, r_l}) ? 33'({2'b0, r_l} - r_lp) :
                               33'(r_lp - {2'b0, r_l});
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_mag   <= r_min * r_diff;
                    r_state <= ST_QGO;
                end
                ST_QGO: begin
                    r_div_start <= 1'b1;
                    r_div_num   <= {7'd0, r_mag};
                    r_div_den   <= {12'd0, n_r};
                    r_div_steps <= STEPS_64;
                    r_state     <= ST_DQ;
                end
                ST_DQ: begin
                    if (n_div_done) begin
                        if (r_neg)
                            r_wn <= $signed({28'd0, r_w}) - $signed({2'd0, n_qadj});
                        else
                            r_wn <= $signed({28'd0, r_w}) + $signed({2'd0, n_qadj});
                        r_state <= ST_WN;
                    end
                end
                ST_WN: begin
                    r_wf    <= n_wc;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (r_wf[57:32] != '0 || n_fin[47:32] != '0)
                        r_out_win <= '1;
                    else
                        r_out_win <= n_fin[31:0];
                    r_out_thr   <= r_thr;
                    r_out_act   <= ACT_RECOMP;
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_window    = r_out_win;
    assign o_threshold = r_out_thr;
    assign o_action    = r_out_act;

endmodule

[rtl/core/delay_target_cwnd_controller_unit.sv]
// Top level of the delay-target congestion-window controller.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata 224b, tuser command
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata 64b, tuser action
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// An RTT sample beat passes through the target-update state, a plain ACK beat
// is answered from idle, and a per-round recompute runs its four divisions in
// turn on the shared one-bit-per-cycle divider. A small queue takes further
// beats while the back end works or while a result waits for m_axis_tready.
// Reset is synchronous and active low; the config port is always ready.
module delay_target_cwnd_controller_unit
    import dtcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [23:0] rtt_sample_us, [39:24] acked_segments, [71:40] acked_seq,
    // [103:72] next_send_seq, [127:104] latest_rtt_us, [159:128] inflight_bytes,
    // [191:160] window_bytes, [223:192] threshold_bytes
    input  logic [223:0] s_axis_tdata,
    // [0] command
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] new_window_bytes, [63:32] new_threshold_bytes
    output logic [63:0]  m_axis_tdata,
    // [1:0] action
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    logic [ALPHA_W-1:0] r_alpha;
    logic [SEG_W-1:0]   r_seg;
    logic               n_q_valid;
    logic               n_q_pop;
    t_item              n_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 12'd384;
            r_seg   <= 16'd1448;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_SEG:   r_seg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dtcc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_command (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .o_q_valid (n_q_valid),
        .i_q_pop   (n_q_pop),
        .o_q_item  (n_q_item)
    );

    dtcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_alpha     (r_alpha),
        .i_seg       (r_seg),
        .i_q_valid   (n_q_valid),
        .o_q_pop     (n_q_pop),
        .i_q_item    (n_q_item),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_window    (m_axis_tdata[31:0]),
        .o_threshold (m_axis_tdata[63:32]),
        .o_action    (m_axis_tuser)
    );

endmodule
